>>> src/dmp_pkg.sv
// Shared codes, field widths and transfer structures of the DALI physical-layer core.
`timescale 1ns / 1ps

package dmp_pkg;

    localparam int FWD_W  = 24;
    localparam int BWD_W  = 8;

    // Request kinds carried in the slave-side tuser.
    localparam logic [1:0] REQ_TIMER = 2'd0;
    localparam logic [1:0] REQ_EDGE  = 2'd1;
    localparam logic [1:0] REQ_SEND  = 2'd2;

    localparam logic [1:0] KIND_SHORT = 2'd0;
    localparam logic [1:0] KIND_LONG  = 2'd1;

    localparam logic [2:0] TM_NONE = 3'd0;
    localparam logic [2:0] TM_MIN  = 3'd1;
    localparam logic [2:0] TM_TYP  = 3'd2;
    localparam logic [2:0] TM_MAX  = 3'd3;
    localparam logic [2:0] TM_STOP = 3'd4;

    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_FWD_DONE  = 4'd1;
    localparam logic [3:0] EV_BWD_DONE  = 4'd2;
    localparam logic [3:0] EV_START_ERR = 4'd3;
    localparam logic [3:0] EV_FWD_ERR   = 4'd4;
    localparam logic [3:0] EV_STOP_ERR  = 4'd5;
    localparam logic [3:0] EV_TIMING    = 4'd6;
    localparam logic [3:0] EV_DATA      = 4'd7;
    localparam logic [3:0] EV_SIZE      = 4'd8;

    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_BUSY          = 2'd1;
    localparam logic [1:0] ST_NOT_FREE      = 2'd2;
    localparam logic [1:0] ST_NOT_SUPPORTED = 2'd3;

    typedef struct packed {
        logic [1:0]       req_type;
        logic             rx_level;
        logic [1:0]       frame_kind;
        logic [FWD_W-1:0] fwd_bits;
    } in_item_t;

    typedef struct packed {
        logic             tx_level;
        logic [2:0]       timer_cmd;
        logic [3:0]       event_code;
        logic [BWD_W-1:0] backward_data;
        logic [1:0]       send_status;
    } result_t;

endpackage

>>> src/dmp_in_stage.sv
// Input register stage that captures one request transfer at a time.
`timescale 1ns / 1ps

module dmp_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              consume,
    input  dmp_pkg::in_item_t item_in,
    output logic              valid,
    output dmp_pkg::in_item_t item_out
);

    logic              valid_reg;
    logic              valid_next;
    dmp_pkg::in_item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

>>> src/dmp_engine.sv
// Line state machine: forward frame encoding, collision check and backward frame decoding.
`timescale 1ns / 1ps

module dmp_engine
#(
    parameter int SHORT_FWD_BITS = 16,
    parameter int LONG_FWD_BITS  = 24,
    parameter int BACK_BITS      = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  dmp_pkg::in_item_t item,
    output dmp_pkg::result_t  result
);

    localparam int MAX_FWD = (SHORT_FWD_BITS > LONG_FWD_BITS) ? SHORT_FWD_BITS : LONG_FWD_BITS;
    localparam int MAX_BITS = (MAX_FWD > BACK_BITS) ? MAX_FWD : BACK_BITS;
    localparam int HB_W = $clog2(2 * MAX_BITS + 1);

    localparam logic [HB_W-1:0] HB_SHORT = HB_W'(2 * SHORT_FWD_BITS);
    localparam logic [HB_W-1:0] HB_LONG  = HB_W'(2 * LONG_FWD_BITS);
    localparam logic [HB_W-1:0] HB_BACK  = HB_W'(2 * BACK_BITS);

    typedef enum logic [2:0] {
        LS_STARTUP,
        LS_IDLE,
        LS_FWD_START,
        LS_FWD_FRAME,
        LS_FWD_STOP,
        LS_BWD_START,
        LS_BWD_FRAME,
        LS_BWD_STOP
    } line_state_t;

    line_state_t                 ls_reg, ls_next;
    logic [HB_W-1:0]             hb_reg, hb_next;
    logic                        exp_reg, exp_next;
    logic [dmp_pkg::FWD_W-1:0]   fwd_reg, fwd_next;
    logic [dmp_pkg::BWD_W-1:0]   bwd_reg, bwd_next;
    logic                        drv_reg, drv_next;

    logic [2:0]                  tm;
    logic [3:0]                  ev;
    logic [1:0]                  st;

    // Forward half-bit level and backward half-bit helpers.
    logic [HB_W-1:0]             fidx;
    logic [dmp_pkg::FWD_W-1:0]   fshift;
    logic                        fbit;
    logic                        fwd_lvl;
    logic [HB_W-1:0]             hb_dec;
    logic [dmp_pkg::BWD_W-1:0]   bwd_set;
    logic [2:0]                  bh_tm;

    assign fidx    = hb_reg[0] ? (hb_reg >> 1) : ((hb_reg >> 1) - HB_W'(1));
    assign fshift  = fwd_reg >> fidx;
    assign fbit    = fshift[0];
    assign fwd_lvl = hb_reg[0] ? fbit : ~fbit;

    assign hb_dec  = hb_reg - HB_W'(1);
    assign bwd_set = bwd_reg | (dmp_pkg::BWD_W'(1) << (hb_dec >> 1));
    assign bh_tm   = (hb_dec != '0) ? dmp_pkg::TM_MAX : dmp_pkg::TM_NONE;

    always_comb
    begin
        ls_next  = ls_reg;
        hb_next  = hb_reg;
        exp_next = exp_reg;
        fwd_next = fwd_reg;
        bwd_next = bwd_reg;
        drv_next = drv_reg;
        tm       = dmp_pkg::TM_NONE;
        ev       = dmp_pkg::EV_NONE;
        st       = dmp_pkg::ST_OK;

        unique case (item.req_type)
            dmp_pkg::REQ_SEND:
            begin
                priority if (ls_reg != LS_IDLE)
                begin
                    st = dmp_pkg::ST_BUSY;
                end
                else if (!item.rx_level)
                begin
                    st = dmp_pkg::ST_NOT_FREE;
                end
                else if (item.frame_kind != dmp_pkg::KIND_SHORT &&
                         item.frame_kind != dmp_pkg::KIND_LONG)
                begin
                    st = dmp_pkg::ST_NOT_SUPPORTED;
                end
                else
                begin
                    hb_next  = (item.frame_kind == dmp_pkg::KIND_SHORT) ? HB_SHORT : HB_LONG;
                    fwd_next = item.fwd_bits;
                    ls_next  = LS_FWD_START;
                    drv_next = 1'b0;
                    exp_next = 1'b0;
                    tm       = dmp_pkg::TM_MIN;
                end
            end
            dmp_pkg::REQ_TIMER:
            begin
                unique case (ls_reg)
                    LS_STARTUP:
                    begin
                        ls_next = LS_IDLE;
                    end
                    LS_FWD_START:
                    begin
                        if (item.rx_level != exp_reg)
                        begin
                            ls_next = LS_IDLE;
                            ev      = dmp_pkg::EV_START_ERR;
                        end
                        else
                        begin
                            drv_next = 1'b1;
                            exp_next = 1'b1;
                            ls_next  = LS_FWD_FRAME;
                            tm       = dmp_pkg::TM_MIN;
                        end
                    end
                    LS_FWD_FRAME:
                    begin
                        priority if (item.rx_level != exp_reg)
                        begin
                            ls_next = LS_IDLE;
                            ev      = dmp_pkg::EV_FWD_ERR;
                        end
                        else if (hb_reg == '0)
                        begin
                            ls_next  = LS_FWD_STOP;
                            drv_next = 1'b1;
                            exp_next = 1'b1;
                            tm       = dmp_pkg::TM_STOP;
                        end
                        else
                        begin
                            drv_next = fwd_lvl;
                            exp_next = fwd_lvl;
                            hb_next  = hb_dec;
                            tm       = dmp_pkg::TM_TYP;
                        end
                    end
                    LS_FWD_STOP:
                    begin
                        ls_next = LS_IDLE;
                        ev = (item.rx_level != exp_reg) ? dmp_pkg::EV_STOP_ERR
                                                        : dmp_pkg::EV_FWD_DONE;
                    end
                    LS_BWD_START:
                    begin
                        ls_next = LS_IDLE;
                        ev      = dmp_pkg::EV_TIMING;
                    end
                    LS_BWD_FRAME:
                    begin
                        if (hb_reg == '0)
                        begin
                            ls_next  = LS_BWD_STOP;
                            exp_next = 1'b1;
                            tm       = dmp_pkg::TM_STOP;
                        end
                        else
                        begin
                            hb_next = hb_dec;
                            tm      = bh_tm;
                            if (hb_dec[0])
                            begin
                                exp_next = ~item.rx_level;
                                if (!item.rx_level)
                                begin
                                    bwd_next = bwd_set;
                                end
                            end
                            else
                            begin
                                ls_next = LS_IDLE;
                                ev      = dmp_pkg::EV_TIMING;
                            end
                        end
                    end
                    LS_BWD_STOP:
                    begin
                        ls_next = LS_IDLE;
                        ev      = dmp_pkg::EV_BWD_DONE;
                    end
                    LS_IDLE:
                    begin
                    end
                endcase
            end
            dmp_pkg::REQ_EDGE:
            begin
                unique case (ls_reg)
                    LS_IDLE:
                    begin
                        if (!item.rx_level)
                        begin
                            ls_next  = LS_BWD_START;
                            exp_next = 1'b1;
                            tm       = dmp_pkg::TM_MAX;
                        end
                        else
                        begin
                            ev = dmp_pkg::EV_SIZE;
                        end
                    end
                    LS_BWD_START:
                    begin
                        if (item.rx_level == exp_reg)
                        begin
                            ls_next  = LS_BWD_FRAME;
                            hb_next  = HB_BACK;
                            bwd_next = '0;
                            tm       = dmp_pkg::TM_MAX;
                        end
                        else
                        begin
                            ls_next = LS_IDLE;
                            ev      = dmp_pkg::EV_DATA;
                        end
                    end
                    LS_BWD_FRAME:
                    begin
                        if (hb_reg == '0)
                        begin
                            ls_next  = LS_BWD_STOP;
                            exp_next = 1'b1;
                            tm       = dmp_pkg::TM_STOP;
                        end
                        else
                        begin
                            hb_next = hb_dec;
                            tm      = bh_tm;
                            if (hb_dec[0])
                            begin
                                exp_next = ~item.rx_level;
                                if (!item.rx_level)
                                begin
                                    bwd_next = bwd_set;
                                end
                            end
                            else if (item.rx_level != exp_reg)
                            begin
                                ls_next = LS_IDLE;
                                ev      = dmp_pkg::EV_DATA;
                            end
                        end
                    end
                    LS_BWD_STOP:
                    begin
                        if (item.rx_level != exp_reg)
                        begin
                            ls_next = LS_IDLE;
                            ev      = dmp_pkg::EV_SIZE;
                        end
                    end
                    LS_STARTUP, LS_FWD_START, LS_FWD_FRAME, LS_FWD_STOP:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ls_reg  <= LS_STARTUP;
            hb_reg  <= '0;
            exp_reg <= 1'b0;
            fwd_reg <= '0;
            bwd_reg <= '0;
            drv_reg <= 1'b1;
        end
        else if (advance)
        begin
            ls_reg  <= ls_next;
            hb_reg  <= hb_next;
            exp_reg <= exp_next;
            fwd_reg <= fwd_next;
            bwd_reg <= bwd_next;
            drv_reg <= drv_next;
        end
    end

    always_comb
    begin
        result.tx_level      = drv_next;
        result.timer_cmd     = tm;
        result.event_code    = ev;
        result.backward_data = (ev == dmp_pkg::EV_BWD_DONE) ? bwd_reg : '0;
        result.send_status   = st;
    end

endmodule

>>> src/dmp_out_stage.sv
// Result register that holds one outgoing transfer until the sink takes it.
`timescale 1ns / 1ps

module dmp_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             ready,
    input  dmp_pkg::result_t result_in,
    output logic             valid,
    output dmp_pkg::result_t result_out
);

    logic             valid_reg;
    logic             valid_next;
    dmp_pkg::result_t result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign valid      = valid_reg;
    assign result_out = result_reg;

endmodule

>>> src/dali_manchester_phy_core.sv
// Top level of the DALI Manchester physical-layer core.
//
//  Channel  | Direction | Payload
//  ---------+-----------+----------------------------------------------------
//  s_*      | in        | tuser: req_type, frame_kind; tdata: rx_level, fwd_bits
//  m_*      | out       | tdata: tx_level, timer_cmd, event_code, backward_data,
//           |           |        send_status
//
// Every request yields exactly one result.
// A new request can be taken in every cycle while the sink takes results; the line
// state machine updates as the held request moves into the result register.
// Reset puts the line in startup with the transmit pin at idle level.
// When the result register is held by the sink, the input register holds
// one more request and then the slave side stalls.
`timescale 1ns / 1ps

module dali_manchester_phy_core
#(
    parameter int SHORT_FWD_BITS = 16,
    parameter int LONG_FWD_BITS  = 24,
    parameter int BACK_BITS      = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [0] rx_level, [24:1] fwd_bits, [31:25] zero
    input  logic [3:0]  s_tuser,   // [1:0] req_type, [3:2] frame_kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] tx_level, [3:1] timer_cmd, [7:4] event_code,
                                   // [15:8] backward_data, [17:16] send_status, [23:18] zero
);

    dmp_pkg::in_item_t in_item;
    dmp_pkg::in_item_t held_item;
    dmp_pkg::result_t  step_result;
    dmp_pkg::result_t  out_result;
    logic              held_valid;
    logic              advance;
    logic              s_xfer;

    assign in_item.req_type   = s_tuser[1:0];
    assign in_item.frame_kind = s_tuser[3:2];
    assign in_item.rx_level   = s_tdata[0];
    assign in_item.fwd_bits   = s_tdata[24:1];

    // The held request moves on whenever the result register is free or drains.
    assign advance  = held_valid && (!m_tvalid || m_tready);
    assign s_tready = !held_valid || advance;
    assign s_xfer   = s_tvalid && s_tready;

    dmp_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s_xfer),
        .consume  (advance),
        .item_in  (in_item),
        .valid    (held_valid),
        .item_out (held_item)
    );

    dmp_engine
    #(
        .SHORT_FWD_BITS (SHORT_FWD_BITS),
        .LONG_FWD_BITS  (LONG_FWD_BITS),
        .BACK_BITS      (BACK_BITS)
    )
    u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (held_item),
        .result  (step_result)
    );

    dmp_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .ready      (m_tready),
        .result_in  (step_result),
        .valid      (m_tvalid),
        .result_out (out_result)
    );

    assign m_tdata = {6'd0,
                      out_result.send_status,
                      out_result.backward_data,
                      out_result.event_code,
                      out_result.timer_cmd,
                      out_result.tx_level};

endmodule

>>> sim/tb_dali_manchester_phy_core.sv
// Self-checking testbench for the DALI Manchester physical-layer core.
`timescale 1ns / 1ps

module tb_dali_manchester_phy_core;

    import dmp_pkg::*;

    localparam int SHORT_BITS = 16;
    localparam int LONG_BITS  = 24;
    localparam int BACK_BITS  = 8;
    localparam int N_RANDOM   = 1200;
    localparam int LIMIT      = 150000;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] KIND_PROP  = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    typedef enum logic [2:0] {
        LS_STARTUP, LS_IDLE, LS_FWD_START, LS_FWD_FRAME,
        LS_FWD_STOP, LS_BWD_START, LS_BWD_FRAME, LS_BWD_STOP
    } line_state_t;

    typedef struct packed {
        in_item_t it;
        logic     typed;
        result_t  want;
    } vec_t;

    localparam result_t UNTYPED = '0;
    localparam int N_DIR = 25;

    // Opening sequence: startup, refused sends, aborted forward and backward frames.
    localparam vec_t DIR_TAB [0:N_DIR-1] = '{
        {REQ_SEND,   1'b1, KIND_SHORT, 24'h000000, 1'b1, 1'b1, TM_NONE, EV_NONE, 8'h00, ST_BUSY},
        {REQ_EDGE,   1'b0, KIND_SHORT, 24'h000000, 1'b1, 1'b1, TM_NONE, EV_NONE, 8'h00, ST_OK},
        {REQ_TIMER,  1'b1, KIND_SHORT, 24'h000000, 1'b1, 1'b1, TM_NONE, EV_NONE, 8'h00, ST_OK},
        {REQ_UNUSED, 1'b1, KIND_RSVD,  24'hFFFFFF, 1'b1, 1'b1, TM_NONE, EV_NONE, 8'h00, ST_OK},
        {REQ_TIMER,  1'b1, KIND_SHORT, 24'h000000, 1'b1, 1'b1, TM_NONE, EV_NONE, 8'h00, ST_OK},
        {REQ_EDGE,   1'b1, KIND_SHORT, 24'h000000, 1'b1, 1'b1, TM_NONE, EV_SIZE, 8'h00, ST_OK},
        {REQ_SEND,   1'b0, KIND_SHORT, 24'h123456, 1'b1,
            1'b1, TM_NONE, EV_NONE, 8'h00, ST_NOT_FREE},
        {REQ_SEND,   1'b1, KIND_PROP,  24'h123456, 1'b1,
            1'b1, TM_NONE, EV_NONE, 8'h00, ST_NOT_SUPPORTED},
        {REQ_SEND,   1'b1, KIND_RSVD,  24'h123456, 1'b1,
            1'b1, TM_NONE, EV_NONE, 8'h00, ST_NOT_SUPPORTED},
        {REQ_SEND,   1'b1, KIND_SHORT, 24'hFFFFFF, 1'b1, 1'b0, TM_MIN,  EV_NONE, 8'h00, ST_OK},
        {REQ_EDGE,   1'b1, KIND_SHORT, 24'h000000, 1'b0, UNTYPED},
        {REQ_SEND,   1'b1, KIND_SHORT, 24'h000000, 1'b0, UNTYPED},
        {REQ_TIMER,  1'b0, KIND_SHORT, 24'h000000, 1'b0, UNTYPED},
        {REQ_TIMER,  1'b1, KIND_SHORT, 24'h000000, 1'b0, UNTYPED},
        {REQ_TIMER,  1'b1, KIND_SHORT, 24'h000000, 1'b1,
            1'b0, TM_NONE, EV_FWD_ERR, 8'h00, ST_OK},
        {REQ_SEND,   1'b1, KIND_LONG,  24'h000000, 1'b1, 1'b0, TM_MIN,  EV_NONE, 8'h00, ST_OK},
        {REQ_TIMER,  1'b1, KIND_SHORT, 24'h000000, 1'b1,
            1'b0, TM_NONE, EV_START_ERR, 8'h00, ST_OK},
        {REQ_EDGE,   1'b0, KIND_SHORT, 24'h000000, 1'b0, UNTYPED},
        {REQ_TIMER,  1'b0, KIND_SHORT, 24'h000000, 1'b1,
            1'b0, TM_NONE, EV_TIMING, 8'h00, ST_OK},
        {REQ_EDGE,   1'b0, KIND_SHORT, 24'h000000, 1'b0, UNTYPED},
        {REQ_EDGE,   1'b0, KIND_SHORT, 24'h000000, 1'b1,
            1'b0, TM_NONE, EV_DATA, 8'h00, ST_OK},
        {REQ_EDGE,   1'b0, KIND_SHORT, 24'h000000, 1'b0, UNTYPED},
        {REQ_EDGE,   1'b1, KIND_SHORT, 24'h000000, 1'b0, UNTYPED},
        {REQ_EDGE,   1'b1, KIND_SHORT, 24'h000000, 1'b0, UNTYPED},
        {REQ_TIMER,  1'b0, KIND_SHORT, 24'h000000, 1'b0, UNTYPED}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Line model state.
    line_state_t      line_st;
    logic [5:0]       half_cnt;
    logic             want_lvl;
    logic [FWD_W-1:0] fwd_word;
    logic [BWD_W-1:0] bwd_word;
    logic             pin_lvl;

    result_t pending_results [$];
    int      n_mismatch = 0;
    int      cycle_cnt = 0;
    logic    calm = 1'b0;
    result_t mon_got;
    result_t mon_want;

    dali_manchester_phy_core #(
        .SHORT_FWD_BITS (SHORT_BITS),
        .LONG_FWD_BITS  (LONG_BITS),
        .BACK_BITS      (BACK_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void drive_pin(input logic lvl);
        pin_lvl = lvl;
        want_lvl = lvl;
    endfunction

    function automatic logic fwd_bit(input int idx);
        return (idx < FWD_W) ? fwd_word[idx] : 1'b0;
    endfunction

    // One backward half-bit; returns 1 when it was a mid-bit sample.
    function automatic logic bwd_half(input logic lvl, output logic [2:0] tm);
        int idx;
        half_cnt = half_cnt - 6'd1;
        tm = (half_cnt != 0) ? TM_MAX : TM_NONE;
        if (half_cnt[0])
        begin
            idx = int'(half_cnt) / 2;
            if (!lvl)
            begin
                if (idx < BWD_W)
                    bwd_word[idx] = 1'b1;
                want_lvl = 1'b1;
            end
            else
                want_lvl = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t line_step(input in_item_t it);
        result_t    r;
        logic [2:0] tm;
        logic [3:0] ev;
        logic [1:0] st;
        tm = TM_NONE;
        ev = EV_NONE;
        st = ST_OK;
        case (it.req_type)
            REQ_SEND:
                if (line_st != LS_IDLE)
                    st = ST_BUSY;
                else if (it.rx_level != 1'b1)
                    st = ST_NOT_FREE;
                else if (it.frame_kind != KIND_SHORT && it.frame_kind != KIND_LONG)
                    st = ST_NOT_SUPPORTED;
                else
                begin
                    half_cnt = (it.frame_kind == KIND_SHORT) ? 6'(2 * SHORT_BITS)
                                                             : 6'(2 * LONG_BITS);
                    fwd_word = it.fwd_bits;
                    line_st = LS_FWD_START;
                    drive_pin(1'b0);
                    tm = TM_MIN;
                end
            REQ_TIMER:
                case (line_st)
                    LS_STARTUP:
                        line_st = LS_IDLE;
                    LS_FWD_START:
                        if (it.rx_level != want_lvl)
                        begin
                            line_st = LS_IDLE;
                            ev = EV_START_ERR;
                        end
                        else
                        begin
                            drive_pin(1'b1);
                            line_st = LS_FWD_FRAME;
                            tm = TM_MIN;
                        end
                    LS_FWD_FRAME:
                        if (it.rx_level != want_lvl)
                        begin
                            line_st = LS_IDLE;
                            ev = EV_FWD_ERR;
                        end
                        else if (half_cnt == 0)
                        begin
                            line_st = LS_FWD_STOP;
                            drive_pin(1'b1);
                            tm = TM_STOP;
                        end
                        else
                        begin
                            // Second half of a bit carries the bit, the first half its inverse.
                            if (half_cnt[0])
                                drive_pin(fwd_bit(int'(half_cnt) / 2));
                            else
                                drive_pin(!fwd_bit(int'(half_cnt) / 2 - 1));
                            half_cnt = half_cnt - 6'd1;
                            tm = TM_TYP;
                        end
                    LS_FWD_STOP:
                    begin
                        line_st = LS_IDLE;
                        ev = (it.rx_level != want_lvl) ? EV_STOP_ERR : EV_FWD_DONE;
                    end
                    LS_BWD_START:
                    begin
                        line_st = LS_IDLE;
                        ev = EV_TIMING;
                    end
                    LS_BWD_FRAME:
                        if (half_cnt == 0)
                        begin
                            line_st = LS_BWD_STOP;
                            want_lvl = 1'b1;
                            tm = TM_STOP;
                        end
                        else if (!bwd_half(it.rx_level, tm))
                        begin
                            line_st = LS_IDLE;
                            ev = EV_TIMING;
                        end
                    LS_BWD_STOP:
                    begin
                        line_st = LS_IDLE;
                        ev = EV_BWD_DONE;
                    end
                    default: ;
                endcase
            REQ_EDGE:
                case (line_st)
                    LS_IDLE:
                        if (!it.rx_level)
                        begin
                            line_st = LS_BWD_START;
                            want_lvl = 1'b1;
                            tm = TM_MAX;
                        end
                        else
                            ev = EV_SIZE;
                    LS_BWD_START:
                        if (it.rx_level == want_lvl)
                        begin
                            line_st = LS_BWD_FRAME;
                            half_cnt = 6'(2 * BACK_BITS);
                            bwd_word = '0;
                            tm = TM_MAX;
                        end
                        else
                        begin
                            line_st = LS_IDLE;
                            ev = EV_DATA;
                        end
                    LS_BWD_FRAME:
                        if (half_cnt == 0)
                        begin
                            line_st = LS_BWD_STOP;
                            want_lvl = 1'b1;
                            tm = TM_STOP;
                        end
                        else if (!bwd_half(it.rx_level, tm) && it.rx_level != want_lvl)
                        begin
                            line_st = LS_IDLE;
                            ev = EV_DATA;
                        end
                    LS_BWD_STOP:
                        if (it.rx_level != want_lvl)
                        begin
                            line_st = LS_IDLE;
                            ev = EV_SIZE;
                        end
                    default: ;
                endcase
            default: ;
        endcase
        r.tx_level = pin_lvl;
        r.timer_cmd = tm;
        r.event_code = ev;
        r.backward_data = (ev == EV_BWD_DONE) ? bwd_word : '0;
        r.send_status = st;
        return r;
    endfunction

    // Mostly well-formed line traffic for the current line state, with some junk.
    function automatic in_item_t pick_item(output logic filler);
        in_item_t    it;
        int unsigned roll;
        roll = $urandom_range(999);
        filler = 1'b0;
        it.req_type = REQ_TIMER;
        it.rx_level = want_lvl;
        it.frame_kind = 2'($urandom_range(1));
        it.fwd_bits = 24'($urandom);
        case (line_st)
            LS_IDLE:
                if (roll < 100)
                begin
                    it.req_type = 2'($urandom_range(3));
                    it.rx_level = 1'($urandom_range(1));
                    it.frame_kind = 2'($urandom_range(3));
                    filler = 1'b1;
                end
                else if (roll < 550)
                begin
                    it.req_type = REQ_SEND;
                    it.rx_level = 1'b1;
                end
                else
                begin
                    it.req_type = REQ_EDGE;
                    it.rx_level = 1'b0;
                end
            LS_FWD_START, LS_FWD_FRAME, LS_FWD_STOP:
                if (roll < 4)
                    it.rx_level = !want_lvl;
                else if (roll < 30)
                begin
                    it.req_type = ($urandom_range(1) != 0) ? REQ_EDGE : REQ_SEND;
                    it.rx_level = 1'($urandom_range(1));
                    filler = 1'b1;
                end
            LS_BWD_START:
                if (roll < 15)
                begin
                    it.req_type = ($urandom_range(1) != 0) ? REQ_EDGE : REQ_TIMER;
                    it.rx_level = 1'($urandom_range(1));
                end
                else
                    it.req_type = REQ_EDGE;
            LS_BWD_FRAME:
                if (roll < 10)
                begin
                    it.req_type = 2'($urandom_range(3));
                    it.rx_level = 1'($urandom_range(1));
                end
                else if (half_cnt == 0 || !half_cnt[0])
                begin
                    // Stop point or mid-bit sample: either a timer or an edge will do.
                    it.req_type = ($urandom_range(1) != 0) ? REQ_EDGE : REQ_TIMER;
                    it.rx_level = 1'($urandom_range(1));
                end
                else
                    it.req_type = REQ_EDGE;
            LS_BWD_STOP:
                if (roll < 150)
                begin
                    it.req_type = REQ_EDGE;
                    it.rx_level = (roll < 30) ? 1'b0 : 1'b1;
                end
            default: ;
        endcase
        return it;
    endfunction

    // Presents one item, waits for its transfer and records what it must produce.
    task automatic issue(input in_item_t it, input logic typed, input result_t want);
        result_t predicted;
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, it.fwd_bits, it.rx_level};
        s_tuser <= {it.frame_kind, it.req_type};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = line_step(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT)
        begin
            $display("tb_dali_manchester_phy_core NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 14);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            mon_got.tx_level = m_tdata[0];
            mon_got.timer_cmd = m_tdata[3:1];
            mon_got.event_code = m_tdata[7:4];
            mon_got.backward_data = m_tdata[15:8];
            mon_got.send_status = m_tdata[17:16];
            if (pending_results.size() == 0)
            begin
                if (n_mismatch < 10)
                    $display("unexpected result tx=%0d tm=%0d ev=%0d bd=%02h st=%0d",
                             mon_got.tx_level, mon_got.timer_cmd, mon_got.event_code,
                             mon_got.backward_data, mon_got.send_status);
                n_mismatch = n_mismatch + 1;
            end
            else
            begin
                mon_want = pending_results.pop_front();
                if (mon_got.tx_level !== mon_want.tx_level
                    || mon_got.timer_cmd !== mon_want.timer_cmd
                    || mon_got.event_code !== mon_want.event_code
                    || mon_got.backward_data !== mon_want.backward_data
                    || mon_got.send_status !== mon_want.send_status)
                begin
                    if (n_mismatch < 10)
                        $display("mismatch tx/tm/ev/bd/st: want %0d/%0d/%0d/%02h/%0d %s",
                                 mon_want.tx_level, mon_want.timer_cmd, mon_want.event_code,
                                 mon_want.backward_data, mon_want.send_status,
                                 $sformatf("got %0d/%0d/%0d/%02h/%0d",
                                           mon_got.tx_level, mon_got.timer_cmd,
                                           mon_got.event_code, mon_got.backward_data,
                                           mon_got.send_status));
                    n_mismatch = n_mismatch + 1;
                end
            end
        end
    end

    initial
    begin
        in_item_t it;
        logic     filler;
        int       n_real;
        logic     drained;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        line_st = LS_STARTUP;
        half_cnt = '0;
        want_lvl = 1'b0;
        fwd_word = '0;
        bwd_word = '0;
        pin_lvl = 1'b1;
        n_real = 0;
        drained = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            if (i > 0)
                sender_gap();
            issue(DIR_TAB[i].it, DIR_TAB[i].typed, DIR_TAB[i].want);
        end
        drain_results();

        while (n_real < N_RANDOM)
        begin
            calm <= (n_real >= 400 && n_real < 650);
            if (n_real == (3 * N_RANDOM) / 4 && !drained)
            begin
                drain_results();
                drained = 1'b1;
            end
            else if (n_real > 0)
                sender_gap();
            it = pick_item(filler);
            issue(it, 1'b0, UNTYPED);
            if (!filler)
                n_real = n_real + 1;
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (n_mismatch == 0 && pending_results.size() == 0)
            $display("tb_dali_manchester_phy_core OK");
        else
            $display("tb_dali_manchester_phy_core NOT OK");
        $finish;
    end

endmodule
